// ----- src/ost_pkg.sv -----
// ----------------------------------------------------------------------------
// Ordered key set: shared package
// Action and status codes, and the word types that pass between the
// controller and the chain of key cells.
// ----------------------------------------------------------------------------
`default_nettype none

package ost_pkg;

  // Width of one stored key.
  localparam int KEY_W = 32;

  // Action codes of the input word.
  localparam logic [1:0] ACT_INS = 2'd0;
  localparam logic [1:0] ACT_DEL = 2'd1;
  localparam logic [1:0] ACT_KTH = 2'd2;
  localparam logic [1:0] ACT_CNT = 2'd3;

  // Status codes of the result word.
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_KRANGE = 2'd1;
  localparam logic [1:0] ST_DROP   = 2'd2;

  // What one cell shows its two neighbours.
  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic             occ;
    logic             lt;
  } link_t;

  // Operation broadcast from the controller to every cell.
  typedef struct packed {
    logic             ins;
    logic             del;
    logic [1:0]       action;
    logic [KEY_W-1:0] value;
  } bcast_t;

endpackage

`default_nettype wire

// ----- src/order_statistic_set_top.sv -----
// Each accepted word steps through the compare, reduce and commit states; the reduce
// state waits out LAT = ceil(log2(CAPACITY) / 4), the register depth of the reduction
// tree (3 at CAPACITY = 1024). A new word is taken only in the idle state, once the
// previous word has committed its result.
// Reset clears the key count and every cell's occupancy; stored keys are
// left as they are. No clearing pass is needed.
// ----------------------------------------------------------------------------
// Ordered key set: top level
// Sorted set of distinct signed keys held in a chain of cells, answering
// insert, delete, k-th smallest and count-below queries.
// ----------------------------------------------------------------------------
`default_nettype none

module order_statistic_set_top #(
  parameter int CAPACITY = 1024
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  in_action,
  input  wire logic [31:0] in_value,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      out_answer,
  output logic [1:0]       out_status
);
  import ost_pkg::*;

  localparam int CW    = $clog2(CAPACITY + 1);
  localparam int L     = $clog2(CAPACITY);
  localparam int LAT   = (L + 3) / 4;
  localparam int LAT_W = $clog2(LAT + 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_CMP  = 2'd1;
  localparam logic [1:0] S_RED  = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0]       state_r, state_nxt;
  logic [LAT_W-1:0] wait_r, wait_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic [1:0]       op_act_r;
  logic [KEY_W-1:0] op_val_r;
  logic             out_valid_r, out_valid_nxt;
  logic [KEY_W-1:0] out_answer_r, out_answer_nxt;
  logic [1:0]       out_status_r, out_status_nxt;

  logic             slot_free;
  logic             do_ins;
  logic             do_del;
  logic             hit;
  logic             k_ok;
  logic [KEY_W-1:0] red_data;
  logic [CW-1:0]    kidx;
  bcast_t           bc;
  logic [KEY_W:0]   root;
  link_t            lnk [CAPACITY+2];
  logic [KEY_W:0]   leaf [CAPACITY];

  assign in_ready   = (state_r == S_IDLE);
  assign out_valid  = out_valid_r;
  assign out_answer = out_answer_r;
  assign out_status = out_status_r;

  // Result of the reduction.
  assign hit      = root[KEY_W];
  assign red_data = root[KEY_W-1:0];
  assign kidx     = op_val_r[CW-1:0] - CW'(1);
  assign k_ok     = !op_val_r[KEY_W-1] && (op_val_r != '0) &&
                    (op_val_r <= KEY_W'(cnt_r));

  assign slot_free = !out_valid_r || out_ready;
  assign do_ins = (state_r == S_DONE) && slot_free && (op_act_r == ACT_INS) &&
                  !hit && (cnt_r != CW'(CAPACITY));
  assign do_del = (state_r == S_DONE) && slot_free && (op_act_r == ACT_DEL) && hit;

  assign bc = '{ins: do_ins, del: do_del, action: op_act_r, value: op_val_r};

  // Sequencer and result word.
  always_comb begin
    state_nxt      = state_r;
    wait_nxt       = wait_r;
    cnt_nxt        = cnt_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_answer_nxt = out_answer_r;
    out_status_nxt = out_status_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_CMP;
        end
      end
      S_CMP: begin
        wait_nxt  = LAT_W'(LAT);
        state_nxt = S_RED;
      end
      S_RED: begin
        wait_nxt = wait_r - LAT_W'(1);
        if (wait_r == LAT_W'(1)) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (slot_free) begin
          state_nxt      = S_IDLE;
          out_valid_nxt  = 1'b1;
          out_answer_nxt = '0;
          out_status_nxt = ST_OK;
          case (op_act_r)
            ACT_INS: begin
              if (!hit && (cnt_r == CW'(CAPACITY))) begin
                out_status_nxt = ST_DROP;
              end
            end
            ACT_KTH: begin
              if (k_ok) begin
                out_answer_nxt = red_data;
              end else begin
                out_status_nxt = ST_KRANGE;
              end
            end
            ACT_CNT: begin
              out_answer_nxt = red_data;
            end
            default: begin
              out_answer_nxt = '0;
            end
          endcase
          if (do_ins) begin
            cnt_nxt = cnt_r + CW'(1);
          end else if (do_del) begin
            cnt_nxt = cnt_r - CW'(1);
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      wait_r      <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      wait_r      <= wait_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      op_act_r <= in_action;
      op_val_r <= in_value;
    end
    out_answer_r <= out_answer_nxt;
    out_status_r <= out_status_nxt;
  end

  // Ends of the chain: a virtual occupied cell below the first key, and an
  // empty one past the last.
  assign lnk[0]          = '{key: '0, occ: 1'b1, lt: 1'b1};
  assign lnk[CAPACITY+1] = '{key: '0, occ: 1'b0, lt: 1'b0};

  // The row of key cells.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    ost_cell #(
      .IDX (i),
      .CW  (CW)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .bc      (bc),
      .kidx    (kidx),
      .from_lo (lnk[i]),
      .from_hi (lnk[i+2]),
      .to_nb   (lnk[i+1]),
      .leaf    (leaf[i])
    );
  end

  // Gather the single answering cell.
  ost_or_tree #(
    .N (CAPACITY),
    .W (KEY_W + 1)
  ) u_tree (
    .clk  (clk),
    .leaf (leaf),
    .root (root)
  );

  // The key count never exceeds the capacity.
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(CAPACITY))
    else $error("key count above capacity");

  // An accepted word always starts the compare step.
  a_accept_seq: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == S_CMP))
    else $error("accepted word did not start compare");

  // A committed insert grows the count by one.
  a_ins_grow: assert property (@(posedge clk) disable iff (!rst_n)
    do_ins |=> (cnt_r == CW'($past(cnt_r) + CW'(1))))
    else $error("insert did not grow count");

  // Insert and delete are never committed together.
  a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    !(do_ins && do_del))
    else $error("insert and delete together");

  // Only a k-th query can report a rank out of range.
  a_krange_kth: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_DONE) && slot_free && (op_act_r != ACT_KTH)) |=>
      (out_status_r != ST_KRANGE))
    else $error("rank status on wrong action");

endmodule

`default_nettype wire

// ----- src/ost_cell.sv -----
// ----------------------------------------------------------------------------
// Ordered key set: key cell
// Holds one slot of the sorted key row. Compares its key with the broadcast
// value, offers its part of the query answer and shifts keys to or from its
// neighbours on an insert or a delete.
// ----------------------------------------------------------------------------
`default_nettype none

module ost_cell #(
  parameter int IDX  = 0,
  parameter int CW   = 11
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire ost_pkg::bcast_t        bc,
  input  wire logic [CW-1:0]          kidx,
  input  wire ost_pkg::link_t         from_lo,
  input  wire ost_pkg::link_t         from_hi,
  output ost_pkg::link_t              to_nb,
  output logic [ost_pkg::KEY_W:0]     leaf
);
  import ost_pkg::*;

  logic [KEY_W-1:0] key_r, key_nxt;
  logic             occ_r, occ_nxt;
  logic             lt_r, lt_nxt;
  logic             eq_r, eq_nxt;
  logic             at_pos;
  logic             boundary;
  logic [KEY_W-1:0] data;

  // Compare the held key with the broadcast value.
  always_comb begin
    lt_nxt = occ_r && ($signed(key_r) < $signed(bc.value));
    eq_nxt = occ_r && (key_r == bc.value);
  end

  // This cell is the insertion point when its left neighbour is below the
  // value and it is not. It is the last key below the value when its right
  // neighbour is not below.
  assign at_pos   = !lt_r && from_lo.lt;
  assign boundary = lt_r && !from_hi.lt;

  // Contribution to the reduction tree.
  always_comb begin
    case (bc.action)
      ACT_KTH: data = (occ_r && (kidx == CW'(IDX))) ? key_r : '0;
      ACT_CNT: data = boundary ? KEY_W'(IDX + 1) : '0;
      default: data = '0;
    endcase
  end

  assign leaf  = {at_pos && eq_r, data};
  assign to_nb = '{key: key_r, occ: occ_r, lt: lt_r};

  // Shift right from the insertion point, or left onto the deleted key.
  always_comb begin
    key_nxt = key_r;
    occ_nxt = occ_r;
    if (bc.ins && !lt_r) begin
      key_nxt = at_pos ? bc.value : from_lo.key;
      occ_nxt = from_lo.occ;
    end else if (bc.del && !lt_r) begin
      key_nxt = from_hi.key;
      occ_nxt = from_hi.occ;
    end
  end

  // Occupancy is control state and is cleared by reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= 1'b0;
    end else begin
      occ_r <= occ_nxt;
    end
  end

  // Key and compare flags need no reset.
  always_ff @(posedge clk) begin
    key_r <= key_nxt;
    lt_r  <= lt_nxt;
    eq_r  <= eq_nxt;
  end

endmodule

`default_nettype wire

// ----- src/ost_or_tree.sv -----
// ----------------------------------------------------------------------------
// Ordered key set: reduction tree
// Binary OR tree over the cell outputs, with a register every four levels.
// At most one cell drives a non-zero data field, so the OR is a select.
// ----------------------------------------------------------------------------
`default_nettype none

module ost_or_tree #(
  parameter int N = 1024,
  parameter int W = 33
) (
  input  wire logic         clk,
  input  wire logic [W-1:0] leaf [N],
  output logic [W-1:0]      root
);

  localparam int L = $clog2(N);
  localparam int P = 1 << L;

  // Depth of a node in heap order.
  function automatic int node_depth(input int v);
    int d;
    int x;
    d = 0;
    x = v;
    while (x > 1) begin
      x = x >> 1;
      d = d + 1;
    end
    return d;
  endfunction

  logic [W-1:0] node [1:2*P-1];

  // Leaves, padded with zero up to a power of two.
  for (genvar j = 0; j < P; j++) begin : g_leaf
    if (j < N) begin : g_used
      assign node[P+j] = leaf[j];
    end else begin : g_pad
      assign node[P+j] = '0;
    end
  end

  // Inner nodes; every fourth level is registered, the root always.
  for (genvar i = 1; i < P; i++) begin : g_node
    if (node_depth(i) % 4 == 0) begin : g_reg
      logic [W-1:0] node_r;
      always_ff @(posedge clk) begin
        node_r <= node[2*i] | node[2*i+1];
      end
      assign node[i] = node_r;
    end else begin : g_comb
      assign node[i] = node[2*i] | node[2*i+1];
    end
  end

  assign root = node[1];

endmodule

`default_nettype wire

// ----- dv/order_statistic_set_monitor.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ordered key set: result monitor
// Watches both channels of the ordered key set. Each accepted input word
// updates a private sorted copy of the key set and queues the answer and
// status that the block should return. Each accepted result word is checked
// against the oldest queued answer, field by field.
// ----------------------------------------------------------------------------

module order_statistic_set_monitor #(
  parameter int CAPACITY = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [1:0]  in_action,
  input  logic [31:0] in_value,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [31:0] out_answer,
  input  logic [1:0]  out_status,
  output int          mismatches,
  output int          pending_words
);
  import ost_pkg::*;

  typedef struct packed {
    logic [31:0] answer;
    logic [1:0]  status;
  } answer_t;

  // Our own copy of the set, kept in ascending signed order.
  logic signed [31:0] held_keys[$];
  // Answers still owed by the block, oldest first.
  answer_t            owed_answers[$];
  int                 results_seen;

  // Print one line per mismatch and count it.
  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("result %0d: %s got %0h, wanted %0h (t=%0t)", results_seen, what,
             got, want, $realtime);
    mismatches++;
  endtask

  // Number of held keys strictly below v, by binary search.
  function automatic int keys_below(input logic signed [31:0] v);
    int lo;
    int hi;
    int mid;
    lo = 0;
    hi = held_keys.size();
    while (lo < hi) begin
      mid = lo + (hi - lo) / 2;
      if (held_keys[mid] < v) lo = mid + 1;
      else hi = mid;
    end
    return lo;
  endfunction

  // Apply one input word to the copy of the set and work out its answer.
  function automatic answer_t apply_word(input logic [1:0] act, input logic [31:0] val);
    answer_t r;
    int      pos;
    logic    present;
    r.answer = '0;
    r.status = ST_OK;
    pos      = keys_below(val);
    present  = (pos < held_keys.size()) && (held_keys[pos] == val);
    case (act)
      ACT_INS: begin
        // A duplicate changes nothing, even when the set is full.
        if (!present) begin
          if (held_keys.size() >= CAPACITY) r.status = ST_DROP;
          else held_keys.insert(pos, val);
        end
      end
      ACT_DEL: begin
        if (present) held_keys.delete(pos);
      end
      ACT_KTH: begin
        // Ranks count from one; zero, negative or beyond the count are rejected.
        if (val[31] || val == '0 || val > held_keys.size()) r.status = ST_KRANGE;
        else r.answer = held_keys[val - 1];
      end
      default: begin
        r.answer = pos;
      end
    endcase
    return r;
  endfunction

  // Results are checked before new words are applied; the block cannot answer
  // a word at the edge that accepts it.
  always @(posedge clk) begin : watch
    answer_t want;
    if (!rst_n) begin
      held_keys.delete();
      owed_answers.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (owed_answers.size() == 0) begin
          report_mismatch("unrequested result word, answer", out_answer, '0);
        end else begin
          want = owed_answers.pop_front();
          if (out_answer !== want.answer) report_mismatch("answer", out_answer, want.answer);
          if (out_status !== want.status) report_mismatch("status", out_status, want.status);
        end
        results_seen++;
      end
      if (in_valid && in_ready) owed_answers.push_back(apply_word(in_action, in_value));
    end
    pending_words <= owed_answers.size();
  end

endmodule

// ----- dv/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ordered key set: testbench top
// Drives insert, delete, k-th smallest and count-below words into the block
// with random gaps and back-pressure. A short directed run covers the empty
// set, the extreme keys and the rank limits; the random run then fills the
// set past its capacity and churns it while full.
// ----------------------------------------------------------------------------

module testbench;
  import ost_pkg::*;

  localparam int CAPACITY    = 1024;
  // Distinct keys offered while filling; well above capacity so drops occur.
  localparam int FILL_KEYS   = 1150;
  localparam int MIXED_WORDS = 180;
  localparam int TAIL_CYCLES = 20;
  localparam int CYCLE_LIMIT = 800000;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  in_action;
  logic [31:0] in_value;
  logic        out_valid;
  logic        out_ready;
  logic [31:0] out_answer;
  logic [1:0]  out_status;

  int mismatches;
  int pending_words;
  int cycle_count;
  int words_sent;
  int fill_next;
  bit burst;
  bit drained;
  int stall_left;
  int stall_mode;
  int ready_ticks;

  // 12 ns clock.
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  order_statistic_set_top #(.CAPACITY(CAPACITY)) DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_action  (in_action),
    .in_value   (in_value),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_answer (out_answer),
    .out_status (out_status)
  );

  order_statistic_set_monitor #(.CAPACITY(CAPACITY)) u_monitor (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_action     (in_action),
    .in_value      (in_value),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_answer    (out_answer),
    .out_status    (out_status),
    .mismatches    (mismatches),
    .pending_words (pending_words)
  );

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Result back-pressure: quiet, light and heavy stretches, mostly short stalls.
  always @(negedge clk) begin
    ready_ticks++;
    if (ready_ticks % 200 == 0) stall_mode = $urandom_range(2);
    if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else if (stall_mode != 0 &&
                 $urandom_range(99) < ((stall_mode == 1) ? 15 : 40)) begin
      stall_left = ($urandom_range(19) == 0) ? $urandom_range(15, 40) : $urandom_range(3);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Keys of the working pool; an odd multiplier keeps them distinct.
  function automatic logic [31:0] pool_key(input logic [31:0] idx);
    return idx * 32'h9E37_79B1;
  endfunction

  // A key that is often held, sometimes random, an extreme or a near miss.
  function automatic logic [31:0] pick_key(input int limit);
    int r;
    r = $urandom_range(99);
    if (r < 70) return pool_key($urandom_range(0, limit));
    if (r < 85) return $urandom;
    if (r < 93) begin
      case ($urandom_range(4))
        0:       return 32'h8000_0000;
        1:       return 32'h7FFF_FFFF;
        2:       return 32'h0000_0000;
        3:       return 32'hFFFF_FFFF;
        default: return 32'h0000_0001;
      endcase
    end
    if ($urandom_range(1) == 1) return pool_key($urandom_range(0, limit)) + 32'd1;
    return pool_key($urandom_range(0, limit)) - 32'd1;
  endfunction

  // A rank for the k-th query, mostly in range and sometimes well outside it.
  function automatic logic [31:0] pick_rank();
    int r;
    r = $urandom_range(99);
    if (r < 60) return $urandom_range(1, CAPACITY + 6);
    if (r < 70) return 32'd0;
    if (r < 78) return $urandom | 32'h8000_0000;
    if (r < 86) return $urandom;
    if (r < 94) return $urandom_range(CAPACITY - 14, CAPACITY + 6);
    return 32'd1;
  endfunction

  function automatic int pick_gap();
    int r;
    if (burst) return 0;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(15, 40);
  endfunction

  // Present one word from a falling edge and return at the falling edge after
  // it has been accepted.
  task automatic send_word(input logic [1:0] act, input logic [31:0] val);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid  <= 1'b1;
    in_action <= act;
    in_value  <= val;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    words_sent++;
    if (words_sent % 120 == 0) burst = ($urandom_range(3) == 0);
  endtask

  // Hold off the sender until every outstanding result has come back.
  task automatic wait_for_results();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending_words != 0);
  endtask

  initial begin
    int r;
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_action  = ACT_INS;
    in_value   = '0;
    out_ready  = 1'b0;
    burst      = 1'b0;
    drained    = 1'b0;
    fill_next  = 0;
    stall_mode = 1;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Empty set: no rank is valid, nothing is below anything, deletes are ignored.
    send_word(ACT_KTH, 32'd1);
    send_word(ACT_CNT, 32'h0000_0000);
    send_word(ACT_DEL, 32'd5);
    // Extreme keys and a duplicate.
    send_word(ACT_INS, 32'h7FFF_FFFF);
    send_word(ACT_INS, 32'h8000_0000);
    send_word(ACT_INS, 32'h0000_0000);
    send_word(ACT_INS, 32'hFFFF_FFFF);
    send_word(ACT_INS, 32'h0000_0000);
    // Rank limits: zero, negative, most negative, first, last, one past last.
    send_word(ACT_KTH, 32'd0);
    send_word(ACT_KTH, 32'hFFFF_FFFF);
    send_word(ACT_KTH, 32'h8000_0000);
    send_word(ACT_KTH, 32'd1);
    send_word(ACT_KTH, 32'd4);
    send_word(ACT_KTH, 32'd5);
    // Counts at both ends of the key range.
    send_word(ACT_CNT, 32'h8000_0000);
    send_word(ACT_CNT, 32'h7FFF_FFFF);
    send_word(ACT_CNT, 32'h0000_0000);
    // Delete a present key, then the same key again once it is absent.
    send_word(ACT_DEL, 32'hFFFF_FFFF);
    send_word(ACT_DEL, 32'hFFFF_FFFF);
    send_word(ACT_CNT, 32'h0000_0001);
    send_word(ACT_KTH, 32'd3);
    send_word(ACT_INS, 32'h5555_5555);
    send_word(ACT_INS, 32'hAAAA_AAAA);
    send_word(ACT_KTH, 32'd2);
    wait_for_results();

    // Fill: mostly fresh keys, so the set reaches capacity and then drops.
    while (fill_next < FILL_KEYS) begin
      if (fill_next == 600 && !drained) begin
        wait_for_results();
        drained = 1'b1;
      end
      r = $urandom_range(99);
      if (r < 85) begin
        send_word(ACT_INS, pool_key(fill_next));
        fill_next++;
      end else if (r < 89) begin
        send_word(ACT_INS, pick_key(fill_next));
      end else if (r < 93) begin
        send_word(ACT_DEL, pick_key(fill_next));
      end else if (r < 96) begin
        send_word(ACT_KTH, pick_rank());
      end else begin
        send_word(ACT_CNT, pick_key(fill_next));
      end
    end

    // Churn around capacity: deletes open room that inserts take again.
    repeat (MIXED_WORDS) begin
      r = $urandom_range(99);
      if (r < 25) send_word(ACT_INS, pick_key(fill_next + 100));
      else if (r < 55) send_word(ACT_DEL, pick_key(fill_next));
      else if (r < 80) send_word(ACT_KTH, pick_rank());
      else send_word(ACT_CNT, pick_key(fill_next));
    end

    wait_for_results();
    repeat (TAIL_CYCLES) @(negedge clk);
    if (mismatches == 0 && pending_words == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
